@@ rtl/msfd_pkg.sv @@
// Shared types and constants of the multi-server FIFO dispatcher.
// Holds result field widths, event codes, register indexes and control bundles.
// Depends on nothing; every other file of the block imports it.
package msfd_pkg;

  // Result field widths
  localparam int KIND_W   = 3;
  localparam int PORT_W   = 3;
  localparam int ID_W     = 16;
  localparam int ETIME_W  = 20;
  localparam int SVC_W    = 16;
  localparam int QLEN_W   = 7;
  localparam int SERVED_W = 32;
  localparam int WSUM_W   = 40;

  // Configuration register widths and bus widths
  localparam int CNT_W   = 4;
  localparam int START_W = 17;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;
  localparam int ACT_W   = CNT_W + 1;

  // Register reset values
  localparam logic [CNT_W-1:0]   SERVER_COUNT_RESET = 4'd5;
  localparam logic [START_W-1:0] START_TIME_RESET   = 17'd32400;

  // Register index, taken from paddr[2]
  localparam logic REG_SERVER_COUNT = 1'b0;
  localparam logic REG_START_TIME   = 1'b1;

  // Event kinds
  localparam logic [KIND_W-1:0] KIND_ARRIVE  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SERVE   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_EXIT    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SUMMARY = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DROP    = 3'd4;

  // One result item
  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [PORT_W-1:0]   port;
    logic [ID_W-1:0]     job_id;
    logic [ETIME_W-1:0]  event_time;
    logic [ETIME_W-1:0]  wait_time;
    logic [SVC_W-1:0]    job_service;
    logic [QLEN_W-1:0]   queue_length;
    logic [SERVED_W-1:0] served_total;
    logic [WSUM_W-1:0]   wait_sum;
    logic                last;
  } result_t;

  // Job queue controls
  typedef struct packed {
    logic push;   // write at tail
    logic rd;     // read head entry (data next cycle)
    logic pop;    // advance head
  } queue_ctl_t;

  // Port table controls
  typedef struct packed {
    logic rd;     // read entry (data next cycle)
    logic wr;     // load entry and mark busy
    logic free;   // mark idle
  } port_ctl_t;

endpackage

@@ rtl/multi_server_fifo_dispatcher_top.sv @@
// Top level of the multi-server FIFO dispatcher: tick sequencer, counters,
// register port and result register. Uses msfd_queue and msfd_port_table.
// Depends on msfd_pkg.
//
//  channel | handshake                     | payload
//  --------+-------------------------------+---------------------------------------
//  cfg     | psel penable pwrite pready    | paddr pwdata prdata
//  in      | in_valid in_ready             | arrives service_time
//  out     | out_valid out_ready           | kind port job_id event_time wait_time
//          |                               | job_service queue_length served_total
//          |                               | wait_sum last
//
// One tick at a time: accept the tick, handle the arrival, scan all ports to
// release finished jobs (a busy port is read, then checked), scan the active
// ports to serve queued jobs while the queue holds any (a free port reads the
// queue head, then emits), then emit the summary. The port table and job queue
// memories each give one entry a cycle. Every result waits for a free result
// register, so out_ready stalls the scan. Reset is synchronous; the memories need no clearing.
module multi_server_fifo_dispatcher_top import msfd_pkg::*; #(
  parameter int PORTS       = 8,
  parameter int QUEUE_DEPTH = 64,
  parameter int TIME_BITS   = 20
) (
  input  logic                clk,
  input  logic                rst,
  // register port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready,
  // tick input
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                arrives,
  input  logic [SVC_W-1:0]    service_time,
  // results
  output logic                out_valid,
  input  logic                out_ready,
  output logic [KIND_W-1:0]   kind,
  output logic [PORT_W-1:0]   port,
  output logic [ID_W-1:0]     job_id,
  output logic [ETIME_W-1:0]  event_time,
  output logic [ETIME_W-1:0]  wait_time,
  output logic [SVC_W-1:0]    job_service,
  output logic [QLEN_W-1:0]   queue_length,
  output logic [SERVED_W-1:0] served_total,
  output logic [WSUM_W-1:0]   wait_sum,
  output logic                last
);

  localparam int PW  = (PORTS > 1) ? $clog2(PORTS) : 1;
  localparam int CW  = $clog2(PORTS + 1);
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_ARR      = 3'd1;
  localparam logic [2:0] S_REL_REQ  = 3'd2;
  localparam logic [2:0] S_REL_CHK  = 3'd3;
  localparam logic [2:0] S_SRV_REQ  = 3'd4;
  localparam logic [2:0] S_SRV_EMIT = 3'd5;
  localparam logic [2:0] S_SUM      = 3'd6;

  // Registers
  logic [2:0]           state, state_next;
  logic [CW-1:0]        idx, idx_next;
  logic                 arr_flag;
  logic [SVC_W-1:0]     arr_svc;
  logic [TIME_BITS-1:0] clock_seconds, clock_next;
  logic [ID_W-1:0]      next_id, next_id_next;
  logic [SERVED_W-1:0]  served_counter, served_next;
  logic [WSUM_W-1:0]    wait_accumulator, wsum_next;
  logic [CNT_W-1:0]     server_count;
  logic [START_W-1:0]   start_base;
  result_t              res, res_next;
  logic                 emit;

  // Submodule links
  queue_ctl_t           qctl;
  port_ctl_t            pctl;
  logic [ID_W-1:0]      q_rd_id;
  logic [TIME_BITS-1:0] q_rd_arrival;
  logic [SVC_W-1:0]     q_rd_service;
  logic [QCW-1:0]       q_count;
  logic                 q_full;
  logic [PORTS-1:0]     p_busy;
  logic [TIME_BITS-1:0] p_rd_end;
  logic [ID_W-1:0]      p_rd_id;
  logic [SVC_W-1:0]     p_rd_service;
  logic [TIME_BITS-1:0] p_wr_end;

  logic                 slot_free;
  logic                 cfg_wr;
  logic [PW-1:0]        idx_p;
  logic                 idx_last;
  logic [ACT_W-1:0]     active;
  logic [TIME_BITS-1:0] q_wait;

  msfd_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TIME_BITS   (TIME_BITS)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .ctl        (qctl),
    .wr_id      (next_id_next),
    .wr_arrival (clock_seconds),
    .wr_service (arr_svc),
    .rd_id      (q_rd_id),
    .rd_arrival (q_rd_arrival),
    .rd_service (q_rd_service),
    .count      (q_count),
    .full       (q_full)
  );

  msfd_port_table #(
    .PORTS     (PORTS),
    .TIME_BITS (TIME_BITS)
  ) u_ports (
    .clk        (clk),
    .rst        (rst),
    .ctl        (pctl),
    .index      (idx_p),
    .wr_end     (p_wr_end),
    .wr_id      (q_rd_id),
    .wr_service (q_rd_service),
    .busy       (p_busy),
    .rd_end     (p_rd_end),
    .rd_id      (p_rd_id),
    .rd_service (p_rd_service)
  );

  // Register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[2])
      REG_SERVER_COUNT: prdata = DATA_W'(server_count);
      REG_START_TIME:   prdata = DATA_W'(start_base);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      server_count <= SERVER_COUNT_RESET;
      start_base   <= START_TIME_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_SERVER_COUNT) begin
        server_count <= pwdata[CNT_W-1:0];
      end else begin
        start_base <= pwdata[START_W-1:0];
      end
    end
  end

  // Scan helpers
  assign slot_free = !out_valid || out_ready;
  assign idx_p     = idx[PW-1:0];
  assign idx_last  = (idx == CW'(PORTS - 1));
  assign active    = ({1'b0, server_count} > ACT_W'(PORTS)) ? ACT_W'(PORTS)
                                                            : {1'b0, server_count};
  assign q_wait    = clock_seconds - q_rd_arrival;
  assign p_wr_end  = clock_seconds + TIME_BITS'(q_rd_service);
  assign in_ready  = (state == S_IDLE);

  // Tick sequencer
  always_comb begin
    state_next   = state;
    idx_next     = idx;
    clock_next   = clock_seconds;
    next_id_next = next_id;
    served_next  = served_counter;
    wsum_next    = wait_accumulator;
    qctl         = '0;
    pctl         = '0;
    emit         = 1'b0;
    res_next              = '0;
    res_next.event_time   = ETIME_W'(clock_seconds);
    res_next.queue_length = QLEN_W'(q_count);

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_ARR;
          idx_next   = '0;
        end
      end

      // arrival: push or drop
      S_ARR: begin
        if (!arr_flag) begin
          state_next = S_REL_REQ;
        end else if (slot_free) begin
          emit                 = 1'b1;
          next_id_next         = next_id + ID_W'(1);
          res_next.job_id      = next_id_next;
          res_next.job_service = arr_svc;
          if (!q_full) begin
            qctl.push             = 1'b1;
            res_next.kind         = KIND_ARRIVE;
            res_next.queue_length = QLEN_W'(q_count + QCW'(1));
          end else begin
            res_next.kind = KIND_DROP;
          end
          state_next = S_REL_REQ;
        end
      end

      // release scan over all ports
      S_REL_REQ: begin
        if (p_busy[idx_p]) begin
          pctl.rd    = 1'b1;
          state_next = S_REL_CHK;
        end else if (idx_last) begin
          idx_next   = '0;
          state_next = S_SRV_REQ;
        end else begin
          idx_next = idx + CW'(1);
        end
      end

      S_REL_CHK: begin
        if (p_rd_end != clock_seconds || slot_free) begin
          if (p_rd_end == clock_seconds) begin
            emit                 = 1'b1;
            pctl.free            = 1'b1;
            res_next.kind        = KIND_EXIT;
            res_next.port        = PORT_W'(idx);
            res_next.job_id      = p_rd_id;
            res_next.job_service = p_rd_service;
          end
          if (idx_last) begin
            idx_next   = '0;
            state_next = S_SRV_REQ;
          end else begin
            idx_next   = idx + CW'(1);
            state_next = S_REL_REQ;
          end
        end
      end

      // serve scan over active ports
      S_SRV_REQ: begin
        if (ACT_W'(idx) >= active || q_count == '0) begin
          state_next = S_SUM;
        end else if (p_busy[idx_p]) begin
          idx_next = idx + CW'(1);
        end else begin
          qctl.rd    = 1'b1;
          state_next = S_SRV_EMIT;
        end
      end

      S_SRV_EMIT: begin
        if (slot_free) begin
          emit                  = 1'b1;
          qctl.pop              = 1'b1;
          pctl.wr               = 1'b1;
          served_next           = served_counter + SERVED_W'(1);
          wsum_next             = wait_accumulator + WSUM_W'(q_wait);
          res_next.kind         = KIND_SERVE;
          res_next.port         = PORT_W'(idx);
          res_next.job_id       = q_rd_id;
          res_next.wait_time    = ETIME_W'(q_wait);
          res_next.job_service  = q_rd_service;
          res_next.queue_length = QLEN_W'(q_count - QCW'(1));
          idx_next              = idx + CW'(1);
          state_next            = S_SRV_REQ;
        end
      end

      // closing summary, then advance the clock
      S_SUM: begin
        if (slot_free) begin
          emit          = 1'b1;
          res_next.kind = KIND_SUMMARY;
          res_next.last = 1'b1;
          clock_next    = clock_seconds + TIME_BITS'(1);
          state_next    = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    res_next.served_total = served_next;
    res_next.wait_sum     = wsum_next;
  end

  // Control state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      idx              <= '0;
      clock_seconds    <= TIME_BITS'(START_TIME_RESET);
      next_id          <= '0;
      served_counter   <= '0;
      wait_accumulator <= '0;
      out_valid        <= 1'b0;
    end else begin
      state            <= state_next;
      idx              <= idx_next;
      next_id          <= next_id_next;
      served_counter   <= served_next;
      wait_accumulator <= wsum_next;
      if (cfg_wr && paddr[2] == REG_START_TIME) begin
        clock_seconds <= TIME_BITS'(pwdata[START_W-1:0]);
      end else begin
        clock_seconds <= clock_next;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Tick item and result payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      arr_flag <= arrives;
      arr_svc  <= service_time;
    end
    if (emit) begin
      res <= res_next;
    end
  end

  assign kind         = res.kind;
  assign port         = res.port;
  assign job_id       = res.job_id;
  assign event_time   = res.event_time;
  assign wait_time    = res.wait_time;
  assign job_service  = res.job_service;
  assign queue_length = res.queue_length;
  assign served_total = res.served_total;
  assign wait_sum     = res.wait_sum;
  assign last         = res.last;

endmodule

@@ rtl/msfd_queue.sv @@
// Job FIFO of the dispatcher: one synchronous memory with head, tail and count.
// Each entry holds job id, arrival time and service time.
// Depends on msfd_pkg.
module msfd_queue import msfd_pkg::*; #(
  parameter int QUEUE_DEPTH = 64,
  parameter int TIME_BITS   = 20,
  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  queue_ctl_t           ctl,
  input  logic [ID_W-1:0]      wr_id,
  input  logic [TIME_BITS-1:0] wr_arrival,
  input  logic [SVC_W-1:0]     wr_service,
  output logic [ID_W-1:0]      rd_id,
  output logic [TIME_BITS-1:0] rd_arrival,
  output logic [SVC_W-1:0]     rd_service,
  output logic [CW-1:0]        count,
  output logic                 full
);

  localparam int EW = ID_W + TIME_BITS + SVC_W;

  logic [EW-1:0] mem [QUEUE_DEPTH];
  logic [EW-1:0] rd_data;
  logic [AW-1:0] head;
  logic [AW-1:0] tail;
  logic          push_ok;

  assign full    = (count == CW'(QUEUE_DEPTH));
  assign push_ok = ctl.push && !full;

  // Storage: write at tail, registered read at head
  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[tail] <= {wr_id, wr_arrival, wr_service};
    end
    if (ctl.rd) begin
      rd_data <= mem[head];
    end
  end

  assign {rd_id, rd_arrival, rd_service} = rd_data;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push_ok) begin
        tail <= (tail == AW'(QUEUE_DEPTH - 1)) ? '0 : tail + AW'(1);
      end
      if (ctl.pop) begin
        head <= (head == AW'(QUEUE_DEPTH - 1)) ? '0 : head + AW'(1);
      end
      if (push_ok && !ctl.pop) begin
        count <= count + CW'(1);
      end else if (!push_ok && ctl.pop) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

@@ rtl/msfd_port_table.sv @@
// Server port table: busy flags in flops, end time and job in a synchronous memory.
// One entry is read or written per cycle at the index the sequencer gives.
// Depends on msfd_pkg.
module msfd_port_table import msfd_pkg::*; #(
  parameter int PORTS     = 8,
  parameter int TIME_BITS = 20,
  localparam int PW = (PORTS > 1) ? $clog2(PORTS) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  port_ctl_t            ctl,
  input  logic [PW-1:0]        index,
  input  logic [TIME_BITS-1:0] wr_end,
  input  logic [ID_W-1:0]      wr_id,
  input  logic [SVC_W-1:0]     wr_service,
  output logic [PORTS-1:0]     busy,
  output logic [TIME_BITS-1:0] rd_end,
  output logic [ID_W-1:0]      rd_id,
  output logic [SVC_W-1:0]     rd_service
);

  localparam int EW = TIME_BITS + ID_W + SVC_W;

  logic [EW-1:0] mem [PORTS];
  logic [EW-1:0] rd_data;

  // Entry storage
  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[index] <= {wr_end, wr_id, wr_service};
    end
    if (ctl.rd) begin
      rd_data <= mem[index];
    end
  end

  assign {rd_end, rd_id, rd_service} = rd_data;

  // Busy flags
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= '0;
    end else if (ctl.wr) begin
      busy[index] <= 1'b1;
    end else if (ctl.free) begin
      busy[index] <= 1'b0;
    end
  end

endmodule
